// ===== sv/ihcc_pkg.sv =====
// shared types and constants for the ipv4 header check and classify block
package ihcc_pkg;

	// default header length in bytes
	localparam int HeaderBytesDefault = 20;

	// header offsets of interest
	localparam int VersionPos = 0;
	localparam int ProtoPos   = 9;
	localparam int CksumHiPos = 10;
	localparam int CksumLoPos = 11;

	// one's-complement sum start value and fold constant
	localparam logic [16:0] SumInit = 17'h0ffff;
	localparam logic [17:0] SumFold = 18'h0ffff;

	// reset value of the expected version/length byte
	localparam logic [7:0] VersionByteReset = 8'h45;

	// protocol numbers
	localparam logic [7:0] ProtoTcp  = 8'd6;
	localparam logic [7:0] ProtoUdp  = 8'd17;
	localparam logic [7:0] ProtoIcmp = 8'd1;

	// verdict codes
	typedef enum logic [2:0] {
		VERDICT_BAD_VERSION = 3'd0,
		VERDICT_BAD_CKSUM   = 3'd1,
		VERDICT_TCP         = 3'd2,
		VERDICT_UDP         = 3'd3,
		VERDICT_ICMP        = 3'd4,
		VERDICT_OTHER       = 3'd5
	} verdict_t;

	// header summary handed from the accumulator to the classifier
	typedef struct packed {
		logic        last;
		logic [7:0]  version;
		logic [7:0]  protocol;
		logic [15:0] rx_cksum;
		logic [15:0] computed;
	} hdr_sum_t;

endpackage

// ===== sv/ihcc_accum.sv =====
// per-byte header state: position, one's-complement sum and captured fields
module ihcc_accum #(
	parameter int HEADER_BYTES = ihcc_pkg::HeaderBytesDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       header_byte,
	input  logic             start_req,
	output ihcc_pkg::hdr_sum_t summary
);
	import ihcc_pkg::*;

	localparam int PosW = $clog2(HEADER_BYTES + 1);

	logic [PosW-1:0] pos_q;
	logic [16:0]     sum_q;
	logic [7:0]      latch_q;
	logic [7:0]      version_q;
	logic [7:0]      proto_q;
	logic [15:0]     rx_q;

	logic [PosW-1:0] pos_eff;
	logic [16:0]     sum_base;
	logic [7:0]      proto_base;
	logic [15:0]     rx_base;
	logic            active;
	logic            last;
	logic            is_cksum;
	logic [7:0]      counted;
	logic            do_add;
	logic [15:0]     word;
	logic [17:0]     sum_wide;
	logic [17:0]     sum_fold;
	logic [16:0]     sum_next;
	logic [7:0]      latch_next;
	logic [7:0]      version_next;
	logic [7:0]      proto_next;
	logic [15:0]     rx_next;

	// a start byte restarts the header from a clean state
	always_comb begin
		pos_eff    = start_req ? '0 : pos_q;
		sum_base   = start_req ? SumInit : sum_q;
		proto_base = start_req ? 8'h00 : proto_q;
		rx_base    = start_req ? 16'h0000 : rx_q;
		active     = pos_eff < PosW'(HEADER_BYTES);
		last       = pos_eff == PosW'(HEADER_BYTES - 1);
	end

	// field capture and checksum word assembly
	always_comb begin
		is_cksum = (pos_eff == PosW'(CksumHiPos)) || (pos_eff == PosW'(CksumLoPos));
		counted  = is_cksum ? 8'h00 : header_byte;

		version_next = (pos_eff == PosW'(VersionPos)) ? header_byte : version_q;
		proto_next   = (pos_eff == PosW'(ProtoPos)) ? header_byte : proto_base;
		rx_next      = rx_base;
		if (pos_eff == PosW'(CksumHiPos)) begin
			rx_next[15:8] = header_byte;
		end
		if (pos_eff == PosW'(CksumLoPos)) begin
			rx_next[7:0] = header_byte;
		end

		if (!pos_eff[0]) begin
			latch_next = counted;
			word       = {counted, 8'h00};
			do_add     = last;
		end else begin
			latch_next = latch_q;
			word       = {latch_q, counted};
			do_add     = 1'b1;
		end
	end

	// end-around carry add
	always_comb begin
		sum_wide = {1'b0, sum_base} + {2'b00, word};
		sum_fold = (sum_wide > SumFold) ? (sum_wide - SumFold) : sum_wide;
		sum_next = do_add ? sum_fold[16:0] : sum_base;
	end

	// summary of the header as it stands after this byte
	always_comb begin
		summary.last     = active && last;
		summary.version  = version_next;
		summary.protocol = proto_next;
		summary.rx_cksum = rx_next;
		summary.computed = ~sum_next[15:0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= PosW'(HEADER_BYTES);
			sum_q     <= SumInit;
			latch_q   <= 8'h00;
			version_q <= 8'h00;
			proto_q   <= 8'h00;
			rx_q      <= 16'h0000;
		end else if (en && (start_req || active)) begin
			if (active) begin
				pos_q     <= pos_eff + 1'b1;
				sum_q     <= sum_next;
				latch_q   <= latch_next;
				version_q <= version_next;
				proto_q   <= proto_next;
				rx_q      <= rx_next;
			end
		end
	end

endmodule

// ===== sv/ihcc_classify.sv =====
// verdict from the finished header summary
module ihcc_classify (
	input  ihcc_pkg::hdr_sum_t summary,
	input  logic [7:0]         expected_version,
	output ihcc_pkg::verdict_t verdict
);
	import ihcc_pkg::*;

	// version first, then checksum, then protocol
	always_comb begin
		if (summary.version != expected_version) begin
			verdict = VERDICT_BAD_VERSION;
		end else if (summary.rx_cksum != summary.computed) begin
			verdict = VERDICT_BAD_CKSUM;
		end else if (summary.protocol == ProtoTcp) begin
			verdict = VERDICT_TCP;
		end else if (summary.protocol == ProtoUdp) begin
			verdict = VERDICT_UDP;
		end else if (summary.protocol == ProtoIcmp) begin
			verdict = VERDICT_ICMP;
		end else begin
			verdict = VERDICT_OTHER;
		end
	end

endmodule

// ===== sv/ipv4_header_check_classify.sv =====
// top level: input register, header accumulator, classifier and result register
//
// Usage:
//   Packet bytes enter on the s_ stream one per transaction, network order,
//   with s_tuser high on the first header byte. The first HEADER_BYTES bytes
//   after a start are summed and checked; later bytes are dropped silently.
//   A start byte in the middle of a header abandons that header with no result.
//   After the last header byte one result leaves on the m_ stream: verdict,
//   protocol byte and the computed header checksum.
//   cfg_data sets the required version/length byte; write it while idle.
//   Throughput is one byte per cycle while m_ is not stalled. The result of a
//   header reaches m_ through the input register, then through the sum
//   update and classifier into the result register.
//   When m_tready is low with a result waiting, both stages hold and s_tready
//   drops once the input register is also full.
//   Reset clears all valids, leaves the block idle (bytes are payload until a
//   start) and sets the expected version byte to 0x45.
module ipv4_header_check_classify #(
	parameter int HEADER_BYTES = ihcc_pkg::HeaderBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] header_byte
	input  logic        s_tuser,   // [0] start_req
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] verdict, [10:3] protocol_number,
	                               // [26:11] computed_checksum, [31:27] zero
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import ihcc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	logic        proc;
	logic [7:0]  expected_version_q;
	hdr_sum_t    summary;
	verdict_t    verdict;
	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [7:0]  proto_q;
	logic [15:0] computed_q;

	// stall only when a result waits and the receiver holds it
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign proc      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= VersionByteReset;
		end else if (cfg_valid) begin
			expected_version_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	ihcc_accum #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (proc),
		.header_byte(byte_s1),
		.start_req  (start_s1),
		.summary    (summary)
	);

	ihcc_classify u_classify (
		.summary         (summary),
		.expected_version(expected_version_q),
		.verdict         (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && summary.last;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && summary.last) begin
			verdict_q  <= verdict;
			proto_q    <= summary.protocol;
			computed_q <= summary.computed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, computed_q, proto_q, verdict_q};

endmodule
